// ===== sv/bld_pkg.sv =====
// Shared types and constants for the dashed Bresenham line walker.
package bld_pkg;

	localparam int COORD_BITS = 12;
	localparam int ERR_BITS = COORD_BITS + 3;
	localparam int DASH_BITS = 8;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = DASH_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic [DASH_BITS-1:0] dash_t;

	// Operation codes on the opcode field
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_DASH_ON_LENGTH = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DASH_PERIOD    = 1'b1;

	localparam dash_t DASH_ON_RESET = 8'd5;
	localparam dash_t DASH_PERIOD_RESET = 8'd8;

	// Line walker state
	typedef struct packed {
		coord_t walk_x;
		coord_t walk_y;
		coord_t major_end;
		coord_t delta_major;
		coord_t delta_minor;
		err_t   error_term;
		logic   major_is_x;
		logic   minor_decrement;
		dash_t  dash_count;
		logic   dash_enabled;
		logic   line_active;
	} walk_state_t;

	// Result word
	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   visible;
		logic   last_pixel;
		logic   idle;
	} pix_result_t;

	// Dash settings seen by the walker
	typedef struct packed {
		dash_t dash_on_length;
		dash_t dash_period;
	} dash_cfg_t;

endpackage

// ===== sv/bld_if.sv =====
// Valid/ready channel interfaces for command words and pixel words.
interface bld_in_if;
	logic             valid;
	logic             ready;
	logic             opcode;
	bld_pkg::coord_t  x_start;
	bld_pkg::coord_t  y_start;
	bld_pkg::coord_t  x_end;
	bld_pkg::coord_t  y_end;
	logic             dashed;

	modport source (output valid, opcode, x_start, y_start, x_end, y_end, dashed,
		input ready);
	modport sink (input valid, opcode, x_start, y_start, x_end, y_end, dashed,
		output ready);
endinterface

interface bld_out_if;
	logic             valid;
	logic             ready;
	bld_pkg::coord_t  pixel_x;
	bld_pkg::coord_t  pixel_y;
	logic             visible;
	logic             last_pixel;
	logic             idle;

	modport source (output valid, pixel_x, pixel_y, visible, last_pixel, idle,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, visible, last_pixel, idle,
		output ready);
endinterface

// ===== sv/bld_walk.sv =====
// Next-state and result logic for one command word of the line walker.
module bld_walk (
	input  bld_pkg::walk_state_t st,
	input  logic                 opcode,
	input  bld_pkg::coord_t      x_start,
	input  bld_pkg::coord_t      y_start,
	input  bld_pkg::coord_t      x_end,
	input  bld_pkg::coord_t      y_end,
	input  logic                 dashed,
	input  bld_pkg::dash_cfg_t   cfg,
	output bld_pkg::walk_state_t nxt,
	output bld_pkg::pix_result_t res
);

	bld_pkg::coord_t dx, dy;
	logic            maj_x, swap;
	bld_pkg::coord_t x0, y0, x1, y1;
	bld_pkg::coord_t dmaj, dmin;
	bld_pkg::coord_t new_x, new_y, new_major;
	logic            step_minor;
	bld_pkg::dash_t  cnt_inc, cnt_next;
	logic            is_last;

	// Start setup: major axis, endpoint order, deltas
	always_comb begin
		dx = (x_start >= x_end) ? x_start - x_end : x_end - x_start;
		dy = (y_start >= y_end) ? y_start - y_end : y_end - y_start;
		maj_x = (dx >= dy);
		swap = maj_x ? (x_start > x_end) : (y_start > y_end);
		x0 = swap ? x_end : x_start;
		y0 = swap ? y_end : y_start;
		x1 = swap ? x_start : x_end;
		y1 = swap ? y_start : y_end;
		dmaj = maj_x ? dx : dy;
		dmin = maj_x ? dy : dx;
	end

	// One Bresenham step from the held state
	always_comb begin
		step_minor = (st.error_term >= 0);
		new_x = st.walk_x;
		new_y = st.walk_y;
		if (st.major_is_x) begin
			new_x = st.walk_x + 1'b1;
			if (step_minor)
				new_y = st.minor_decrement ? st.walk_y - 1'b1 : st.walk_y + 1'b1;
		end else begin
			new_y = st.walk_y + 1'b1;
			if (step_minor)
				new_x = st.minor_decrement ? st.walk_x - 1'b1 : st.walk_x + 1'b1;
		end
		new_major = st.major_is_x ? new_x : new_y;
		is_last = (new_major == st.major_end);
		// dash counter wraps at the period, or at 256 when the period is zero
		cnt_inc = st.dash_count + 1'b1;
		cnt_next = (cfg.dash_period != '0 && cnt_inc >= cfg.dash_period) ? '0 : cnt_inc;
	end

	// Select by opcode
	always_comb begin
		nxt = st;
		res = '0;
		if (opcode == bld_pkg::OP_START) begin
			nxt.walk_x = x0;
			nxt.walk_y = y0;
			nxt.major_end = maj_x ? x1 : y1;
			nxt.delta_major = dmaj;
			nxt.delta_minor = dmin;
			nxt.major_is_x = maj_x;
			nxt.minor_decrement = maj_x ? (y1 < y0) : (x1 < x0);
			nxt.error_term = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
			nxt.dash_count = '0;
			nxt.dash_enabled = dashed;
			nxt.line_active = (dmaj != '0);
			res.pixel_x = x0;
			res.pixel_y = y0;
			res.visible = !dashed || (cfg.dash_on_length != '0);
			res.last_pixel = (dmaj == '0);
		end else if (!st.line_active) begin
			res.idle = 1'b1;
		end else begin
			nxt.walk_x = new_x;
			nxt.walk_y = new_y;
			if (step_minor)
				nxt.error_term = st.error_term
					+ ($signed({2'b00, st.delta_minor, 1'b0})
					- $signed({2'b00, st.delta_major, 1'b0}));
			else
				nxt.error_term = st.error_term + $signed({2'b00, st.delta_minor, 1'b0});
			nxt.dash_count = cnt_next;
			nxt.line_active = !is_last;
			res.pixel_x = new_x;
			res.pixel_y = new_y;
			res.visible = !st.dash_enabled || (cnt_next < cfg.dash_on_length);
			res.last_pixel = is_last;
		end
	end

endmodule

// ===== sv/bresenham_line_dashed_core.sv =====
// Top level of the dashed Bresenham line walker.
// Each command word is handled as follows: a start word sets up a line and returns its
// first pixel, a step word returns the next pixel (or an idle word when no line is
// active), and words may arrive back to back at one per clock while in_ch.ready is
// high. The rate is set by the combinational error-term update between the walker
// state registers. Results go out through a two-word output buffer, so the input
// side takes one more word after the output stalls; in_ch.ready does not depend on
// out_ch.ready. Config port writes are registered and apply to later words.
module bresenham_line_dashed_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bld_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bld_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	bld_in_if.sink                             in_ch,
	bld_out_if.source                          out_ch
);

	bld_pkg::walk_state_t st_q, st_nxt;
	bld_pkg::dash_cfg_t   cfg_q;
	bld_pkg::pix_result_t res;
	bld_pkg::pix_result_t out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 accept, take;

	assign accept = in_ch.valid && in_ch.ready;
	assign take = out_valid_q && out_ch.ready;
	assign in_ch.ready = !skid_valid_q;

	bld_walk u_walk (
		.st      (st_q),
		.opcode  (in_ch.opcode),
		.x_start (in_ch.x_start),
		.y_start (in_ch.y_start),
		.x_end   (in_ch.x_end),
		.y_end   (in_ch.y_end),
		.dashed  (in_ch.dashed),
		.cfg     (cfg_q),
		.nxt     (st_nxt),
		.res     (res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash_on_length <= bld_pkg::DASH_ON_RESET;
			cfg_q.dash_period <= bld_pkg::DASH_PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bld_pkg::CFG_DASH_ON_LENGTH: cfg_q.dash_on_length <= cfg_data;
				bld_pkg::CFG_DASH_PERIOD:    cfg_q.dash_period <= cfg_data;
				default: ;
			endcase
		end
	end

	// Walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (accept)
			st_q <= st_nxt;
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	// Output buffer words
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || take)
				out_q <= res;
			else
				skid_q <= res;
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.pixel_x = out_q.pixel_x;
	assign out_ch.pixel_y = out_q.pixel_y;
	assign out_ch.visible = out_q.visible;
	assign out_ch.last_pixel = out_q.last_pixel;
	assign out_ch.idle = out_q.idle;

endmodule
